// ----- rtl/mac_learning_forwarding_table_defines.svh -----
// Assertion macros used by the table back end.
`ifndef MAC_LEARNING_FORWARDING_TABLE_DEFINES_SVH
`define MAC_LEARNING_FORWARDING_TABLE_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define MLFT_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// Property checked on every clock edge, reset included.
`define MLFT_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`endif

// ----- rtl/mlft_pkg.sv -----
// Shared types and constants of the learning table.
package mlft_pkg;
  localparam int unsigned TableEntriesDef = 64;
  localparam int unsigned NumPortsDef = 8;
  localparam int unsigned MacW = 48;
  localparam int unsigned PortW = 4;
  localparam int unsigned StampW = 32;
  localparam logic [31:0] AgeLimitRst = 32'd300000;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic {REQ_FRAME = 1'b0, REQ_TICK = 1'b1} req_type_e;

  // One classified item handed from front to back.
  typedef struct packed {
    logic            tick;
    logic [PortW-1:0] port;
    logic [MacW-1:0] dst;
    logic [MacW-1:0] src;
  } cmd_t;
endpackage

// ----- rtl/mac_learning_forwarding_table.sv -----
// Learning bridge table top level.
// A frame item passes the engine states LEARN, AGE and OUT in turn; a tick item goes straight to OUT.
// The table engine takes a new item only when idle, after the last result has been handed over.
// A two-item queue lets input acceptance run ahead of the engine.
// Asynchronous active-low reset clears all entries, the time counter,
// and sets the age limit to 300000.
module mac_learning_forwarding_table #(
  parameter int unsigned TableEntries = mlft_pkg::TableEntriesDef,
  parameter int unsigned NumPorts = mlft_pkg::NumPortsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic         s_axis_tuser,   // req_type
  input  logic [103:0] s_axis_tdata,   // ingress_port, dst_mac, src_mac
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [23:0]  m_axis_tdata,   // fwd_mask, flooded, learned, table_full, entries_used
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [31:0]  cfg_data
);
  import mlft_pkg::*;
  cmd_t cmd;
  logic cmd_valid, cmd_ready;

  mlft_front u_front (
    .clk_i, .rst_ni,
    .s_tvalid_i(s_axis_tvalid), .s_tready_o(s_axis_tready),
    .s_tuser_i(s_axis_tuser), .s_tdata_i(s_axis_tdata),
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd)
  );

  mlft_back #(.TableEntries(TableEntries), .NumPorts(NumPorts)) u_back (
    .clk_i, .rst_ni,
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data),
    .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready), .cmd_i(cmd),
    .m_tvalid_o(m_axis_tvalid), .m_tready_i(m_axis_tready), .m_tdata_o(m_axis_tdata)
  );
endmodule

// ----- rtl/mlft_front.sv -----
// Front end: accepts items and queues them for the table engine.
module mlft_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_tvalid_i,
  output logic           s_tready_o,
  input  logic           s_tuser_i,
  input  logic [103:0]   s_tdata_i,
  output logic           cmd_valid_o,
  input  logic           cmd_ready_i,
  output mlft_pkg::cmd_t cmd_o
);
  import mlft_pkg::*;
  cmd_t q_q [QueueDepth];
  cmd_t in_cmd;
  logic [1:0] cnt_q, cnt_d;
  logic push, pop, to_head;

  assign s_tready_o = (cnt_q != 2'(QueueDepth));
  assign push = s_tvalid_i && s_tready_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop = cmd_valid_o && cmd_ready_i;
  assign cmd_o = q_q[0];
  assign in_cmd = '{s_tuser_i, s_tdata_i[3:0], s_tdata_i[51:4], s_tdata_i[99:52]};
  assign to_head = (cnt_q == 2'd0) || (cnt_q == 2'd1 && pop);

  always_comb begin
    cnt_d = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Two-entry shift queue; the head is always slot zero.
  always_ff @(posedge clk_i) begin
    if (push && to_head) begin
      q_q[0] <= in_cmd;
    end else if (pop) begin
      q_q[0] <= q_q[1];
    end
    if (push && !to_head) begin
      q_q[1] <= in_cmd;
    end
  end
endmodule

// ----- rtl/mlft_back.sv -----
// Back end: table lookup, learning, forwarding decision and aging.
module mlft_back #(
  parameter int unsigned TableEntries = mlft_pkg::TableEntriesDef,
  parameter int unsigned NumPorts = mlft_pkg::NumPortsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [31:0]         cfg_data_i,
  input  logic                cmd_valid_i,
  output logic                cmd_ready_o,
  input  mlft_pkg::cmd_t      cmd_i,
  output logic                m_tvalid_o,
  input  logic                m_tready_i,
  output logic [23:0]         m_tdata_o
);
  import mlft_pkg::*;
  localparam int unsigned CntW = $clog2(TableEntries + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_LEARN, ST_AGE, ST_OUT} state_e;
  state_e state_q;

  logic [TableEntries-1:0] valid_q;
  logic [PortW-1:0]  port_q  [TableEntries];
  logic [MacW-1:0]   mac_q   [TableEntries];
  logic [StampW-1:0] stamp_q [TableEntries];
  logic [31:0] time_q, age_q;
  cmd_t cmd_q;
  logic [7:0] mask_q;
  logic flood_q, learned_q, full_q;
  logic [CntW-1:0] used_q;

  logic [TableEntries-1:0] hit_v, dst_v, free_v, old_v, first_free;
  logic hit, any_free;
  logic [7:0] mask_c;

  always_comb begin
    for (int i = 0; i < TableEntries; i++) begin
      hit_v[i] = valid_q[i] && port_q[i] == cmd_q.port && mac_q[i] == cmd_q.src;
      dst_v[i] = valid_q[i] && mac_q[i] == cmd_q.dst;
      old_v[i] = valid_q[i] && (time_q - stamp_q[i]) >= age_q;
    end
    free_v = ~valid_q;
    first_free = free_v & (~free_v + 1'b1);
    hit = |hit_v;
    any_free = |free_v;
    mask_c = '0;
    for (int i = 0; i < TableEntries; i++) begin
      if (dst_v[i] && port_q[i] >= 4'd1 && port_q[i] <= 4'(NumPorts)) begin
        mask_c[3'(port_q[i] - 4'd1)] = 1'b1;
      end
    end
    if (!(|dst_v)) begin
      for (int p = 1; p <= NumPorts; p++) begin
        if (4'(p) != cmd_q.port) mask_c[p-1] = 1'b1;
      end
    end
  end

  assign cmd_ready_o = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign m_tvalid_o = (state_q == ST_OUT);
  assign m_tdata_o = {6'd0, 7'(used_q), full_q, learned_q, flood_q, mask_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= '0;
      time_q <= '0;
      age_q <= AgeLimitRst;
      used_q <= '0;
      cmd_q <= '0;
      mask_q <= '0;
      flood_q <= 1'b0;
      learned_q <= 1'b0;
      full_q <= 1'b0;
    end else begin
      if (cfg_valid_i) age_q <= cfg_data_i;
      case (state_q)
        ST_IDLE: begin
          if (cmd_valid_i) begin
            cmd_q <= cmd_i;
            if (cmd_i.tick) begin
              time_q <= time_q + 32'd1;
              mask_q <= '0;
              flood_q <= 1'b0;
              learned_q <= 1'b0;
              full_q <= 1'b0;
              state_q <= ST_OUT;
            end else begin
              state_q <= ST_LEARN;
            end
          end
        end
        ST_LEARN: begin
          learned_q <= !hit && any_free;
          full_q <= !hit && !any_free;
          if (!hit && any_free) begin
            valid_q <= valid_q | first_free;
          end
          state_q <= ST_AGE;
        end
        ST_AGE: begin
          mask_q <= mask_c;
          flood_q <= !(|dst_v);
          valid_q <= valid_q & ~old_v;
          used_q <= CntW'($countones(valid_q & ~old_v));
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (m_tready_i) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Entry contents are only read where the valid bit is set, so they need no reset.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_LEARN && !hit && any_free) begin
      for (int i = 0; i < TableEntries; i++) begin
        if (first_free[i]) begin
          port_q[i] <= cmd_q.port;
          mac_q[i] <= cmd_q.src;
          stamp_q[i] <= time_q;
        end
      end
    end
  end

  `include "mac_learning_forwarding_table_defines.svh"
  `MLFT_ASSERT(a_out_hold, clk_i, rst_ni, (m_tvalid_o && !m_tready_i) |=> m_tvalid_o)
  `MLFT_ASSERT_ALWAYS(a_flag_excl, clk_i, !(learned_q && full_q))
  `MLFT_ASSERT(a_used_rng, clk_i, rst_ni, m_tvalid_o |-> used_q <= CntW'(TableEntries))
endmodule
